// ===== src/fixed_point_alu_q24_8_top_assert.svh =====
`ifndef FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
// Assertion helpers: label, clock, reset, antecedent, consequent.
`ifndef SYNTHESIS
`define FPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FPA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define FPA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FPA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/fpa_pkg.sv =====
package fpa_pkg;
   localparam int FracBits = 8;
   localparam int DataW    = 32;
   localparam int NumCells = DataW + FracBits; // one quotient bit per cell
   localparam int RemW     = DataW + 1;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
      OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
   } op_type;

   // Item as it travels down the cell row.
   typedef struct packed {
      logic                    valid;
      logic                    is_div;
      logic                    neg_q;
      logic                    dz;
      logic                    cmp;
      logic [DataW-1:0]        value;   // non-divide result
      logic [NumCells-1:0]     dvd;     // |dividend| << FracBits, shifted out msb first
      logic [DataW-1:0]        dvs;     // |divisor|
      logic [RemW-1:0]         rem;
      logic [NumCells-1:0]     quo;
   } item_type;
endpackage

// ===== src/fpa_if.sv =====
interface fpa_req_if import fpa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [3:0]       func;
   logic [DataW-1:0] operand_a;
   logic [DataW-1:0] operand_b;
   modport source(output valid, func, operand_a, operand_b, input ready);
   modport sink(input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DataW-1:0] value_out;
   logic             compare_true;
   logic             divide_by_zero;
   modport source(output valid, value_out, compare_true, divide_by_zero, input ready);
   modport sink(input valid, value_out, compare_true, divide_by_zero, output ready);
endinterface

// ===== src/fpa_front.sv =====
module fpa_front import fpa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [3:0]       func,
   input  logic [DataW-1:0] operand_a,
   input  logic [DataW-1:0] operand_b,
   output item_type         item_out
);
   logic signed [DataW-1:0]   a, b;
   logic signed [2*DataW-1:0] prod;
   logic [DataW-1:0]          mag_a, mag_b;
   op_type                    op;
   item_type                  item_in, item_ff;
   logic                      lt, gt;

   always_comb begin
      a    = operand_a;
      b    = operand_b;
      op   = op_type'(func);
      prod = a * b;
      lt   = a < b;
      gt   = a > b;
      mag_a = a[DataW-1] ? DataW'(-a) : operand_a;
      mag_b = b[DataW-1] ? DataW'(-b) : operand_b;
      item_in        = '0;
      item_in.valid  = in_valid;
      item_in.is_div = (op == OP_DIV);
      item_in.neg_q  = a[DataW-1] ^ b[DataW-1];
      item_in.dz     = (op == OP_DIV) && (operand_b == '0);
      item_in.dvd    = {mag_a, {FracBits{1'b0}}};
      item_in.dvs    = mag_b;
      case (op)
         OP_ADD:      item_in.value = operand_a + operand_b;
         OP_SUB:      item_in.value = operand_a - operand_b;
         OP_MUL:      item_in.value = prod[FracBits +: DataW];
         OP_LT:       item_in.cmp = lt;
         OP_GT:       item_in.cmp = gt;
         OP_LE:       item_in.cmp = !gt;
         OP_GE:       item_in.cmp = !lt;
         OP_EQ:       item_in.cmp = (operand_a == operand_b);
         OP_NE:       item_in.cmp = (operand_a != operand_b);
         OP_MIN:      item_in.value = lt ? operand_a : operand_b;
         OP_MAX:      item_in.value = gt ? operand_a : operand_b;
         OP_INC:      item_in.value = operand_a + DataW'(1);
         OP_DEC:      item_in.value = operand_a - DataW'(1);
         OP_FROM_INT: item_in.value = operand_a << FracBits;
         OP_TO_INT:   item_in.value = DataW'(a >>> FracBits);
         default:     item_in.value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_out = item_ff;
endmodule

// ===== src/fpa_cell.sv =====
module fpa_cell import fpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  item_type item_in,
   output item_type item_out
);
   item_type         nxt, item_ff;
   logic [RemW-1:0]  shifted, diff;

   // one restoring division step
   always_comb begin
      nxt     = item_in;
      shifted = {item_in.rem[RemW-2:0], item_in.dvd[NumCells-1]};
      diff    = shifted - {1'b0, item_in.dvs};
      nxt.dvd = item_in.dvd << 1;
      if (!diff[RemW-1]) begin
         nxt.rem = diff;
         nxt.quo = {item_in.quo[NumCells-2:0], 1'b1};
      end else begin
         nxt.rem = shifted;
         nxt.quo = {item_in.quo[NumCells-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (en) begin
         item_ff <= nxt;
      end
   end

   assign item_out = item_ff;
endmodule

// ===== src/fixed_point_alu_q24_8_top.sv =====
// Channel  Dir  Signals
// req      in   valid/ready, func, operand_a, operand_b
// rsp      out  valid/ready, value_out, compare_true, divide_by_zero
// A req transfer passes the front register, the cell registers and the output register to rsp valid.
// One transfer accepted per cycle while rsp is not stalled; the cell row holds one item per stage.
// A stalled rsp freezes the whole row; req ready drops only then.
// Synchronous reset clears all valid bits.
`include "fixed_point_alu_q24_8_top_assert.svh"
module fixed_point_alu_q24_8_top import fpa_pkg::*; (
   input logic      clock,
   input logic      reset,
   fpa_req_if.sink  req,
   fpa_rsp_if.source rsp
);
   item_type          chain [NumCells+1];
   logic              en;
   logic              out_valid_ff;
   logic [DataW-1:0]  out_value_ff, qv;
   logic              out_cmp_ff, out_dz_ff;
   item_type          last;

   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   fpa_front u_front (
      .clock, .reset, .en, .in_valid(req.valid), .func(req.func),
      .operand_a(req.operand_a), .operand_b(req.operand_b), .item_out(chain[0])
   );

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      fpa_cell u_cell (
         .clock, .reset, .en, .item_in(chain[i]), .item_out(chain[i+1])
      );
   end

   assign last = chain[NumCells];

   always_comb begin
      qv = last.quo[DataW-1:0];
      if (last.neg_q) qv = DataW'(-qv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= last.valid;
         out_cmp_ff   <= last.cmp;
         out_dz_ff    <= last.dz;
         out_value_ff <= !last.is_div ? last.value : (last.dz ? '0 : qv);
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.value_out      = out_value_ff;
   assign rsp.compare_true   = out_cmp_ff;
   assign rsp.divide_by_zero = out_dz_ff;

   `FPA_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
   `FPA_ASSERT_IMP(a_ready, clock, reset, !rsp.valid, req.ready)
   `FPA_ASSERT_IMP(a_flags, clock, reset, rsp.valid, !(rsp.compare_true && rsp.divide_by_zero))
endmodule

// ===== test/fpa_checker.sv =====
module fpa_checker import fpa_pkg::*; (
   input logic      clock,
   input logic      reset,
   fpa_req_if.sink  req_mon,
   fpa_rsp_if.sink  rsp_mon,
   output int       fail_count,
   output int       pending_count
);
   typedef struct {
      logic [DataW-1:0] value;
      logic             cmp;
      logic             dz;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic alu_result_type compute_alu(op_type op, logic signed [DataW-1:0] a,
                                                  logic signed [DataW-1:0] b);
      alu_result_type r;
      logic signed [63:0] wide;
      logic signed [63:0] num;
      r.value = '0;
      r.cmp = 1'b0;
      r.dz = 1'b0;
      case (op)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: begin
            wide = 64'(a) * 64'(b);
            r.value = 32'(wide >>> FracBits);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               num = 64'(a) <<< FracBits;
               wide = num / 64'(b);
               r.value = wide[DataW-1:0];
            end
         end
         OP_LT: r.cmp = a < b;
         OP_GT: r.cmp = a > b;
         OP_LE: r.cmp = a <= b;
         OP_GE: r.cmp = a >= b;
         OP_EQ: r.cmp = a == b;
         OP_NE: r.cmp = a != b;
         OP_MIN: r.value = (a < b) ? a : b;
         OP_MAX: r.value = (a > b) ? a : b;
         OP_INC: r.value = a + 1;
         OP_DEC: r.value = a - 1;
         OP_FROM_INT: r.value = a << FracBits;
         default: r.value = a >>> FracBits;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alu_result_type exp_r;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(compute_alu(op_type'(req_mon.func),
                                                   req_mon.operand_a, req_mon.operand_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transfer value=%h", $time, rsp_mon.value_out);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_results.pop_front();
               if (exp_r.value !== rsp_mon.value_out || exp_r.cmp !== rsp_mon.compare_true
                   || exp_r.dz !== rsp_mon.divide_by_zero) begin
                  $display("%0t: mismatch expected value=%h cmp=%b dz=%b",
                           $time, exp_r.value, exp_r.cmp, exp_r.dz,
                           " actual value=%h cmp=%b dz=%b", rsp_mon.value_out,
                           rsp_mon.compare_true, rsp_mon.divide_by_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end
endmodule

// ===== test/testbench.sv =====
module testbench import fpa_pkg::*;;
   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   bit   hold_off;

   fpa_req_if req_ch();
   fpa_rsp_if rsp_ch();

   fixed_point_alu_q24_8_top i_dut (.clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch));
   fpa_checker i_checker (.clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
                          .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.operand_a = '0;
      req_ch.operand_b = '0;
      rsp_ch.ready = 1'b0;
      hold_off = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= reset ? 0 : cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 4) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [DataW-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '0;
         3: return 32'(int'($urandom_range(0, 2000)) - 1000);
         4: return 32'hffff_ffff;
         5: return 32'(1) << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_off = 1'b0;
         end
         n = gap_len();
         if (n == 0) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_item(op_type op, logic [DataW-1:0] a, logic [DataW-1:0] b);
      req_ch.valid <= 1'b1;
      req_ch.func <= op;
      req_ch.operand_a <= a;
      req_ch.operand_b <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin
      int gap;
      int wait_cycles;
      @(negedge reset);
      @(posedge clock);
      for (int op = 0; op < 16; op++)
         send_item(op_type'(op), 32'h8000_0000, 32'hffff_ffff);
      send_item(OP_DIV, 32'h1234_5678, '0);
      send_item(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
      send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(OP_EQ, 32'h0000_0100, 32'h0000_0100);
      send_item(OP_MIN, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(OP_INC, 32'h7fff_ffff, '0);
      send_item(OP_TO_INT, 32'hffff_ff01, '0);
      hold_off = 1'b1;
      for (int i = 0; i < 450; i++) begin
         gap = (i < 120) ? 0 : gap_len();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_item(op_type'($urandom_range(0, 15)), pick_operand(),
                   ($urandom_range(0, 15) == 0) ? '0 : pick_operand());
      end
      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (NumCells + 10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
